// File: hw/rtl/ests_pkg.sv
package ests_pkg;

	// input transaction payload
	typedef struct packed {
		logic [31:0] epoch_seconds;
	} stamp_t;

	// result transaction payload
	typedef struct packed {
		logic       valid_res;
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [2:0] weekday;
		logic [7:0] year_since_1900;
		logic [8:0] day_of_year;
		logic [3:0] month;
		logic [4:0] day_of_month;
	} date_t;

	// sequencer phases
	typedef enum logic [7:0] {
		PH_IDLE = 8'b0000_0001,
		PH_DAY  = 8'b0000_0010,
		PH_HOUR = 8'b0000_0100,
		PH_MIN  = 8'b0000_1000,
		PH_YEAR = 8'b0001_0000,
		PH_YDOY = 8'b0010_0000,
		PH_MON  = 8'b0100_0000,
		PH_DOM  = 8'b1000_0000
	} phase_t;

	localparam logic [16:0] DAY_SECS   = 17'd86400;
	localparam logic [11:0] HOUR_SECS  = 12'd3600;
	localparam logic [5:0]  MIN_SECS   = 6'd60;
	localparam logic [15:0] DAY_LIMIT  = 16'd49673;
	localparam logic [7:0]  YEAR_OFS   = 8'd70;
	localparam logic [3:0]  WEEK_DAYS  = 4'd7;
	localparam logic [4:0]  THURSDAY   = 5'd4;
	localparam int          YEAR_COUNT = 136;
	localparam logic [7:0]  IDX_2100   = 8'd130;

	// steps less one per division or search, highest bit first
	localparam logic [3:0] DAY_STEPS_M1  = 4'd15;
	localparam logic [3:0] HOUR_STEPS_M1 = 4'd4;
	localparam logic [3:0] MIN_STEPS_M1  = 4'd5;
	localparam logic [3:0] YEAR_STEPS_M1 = 4'd7;
	localparam logic [3:0] MON_STEPS_M1  = 4'd3;

	typedef logic [15:0] year_tab_t [0:255];
	typedef logic [8:0]  mon_tab_t  [0:15];

	// leap year by offset from 1970, valid through 2105
	function automatic logic leap_of_index(logic [7:0] idx);
		return (idx[1:0] == 2'd2) && (idx != IDX_2100);
	endfunction

	// day number of january 1 for each year, unused slots never match
	function automatic year_tab_t year_start_tab();
		year_tab_t   tab;
		int unsigned d;
		d = 0;
		for (int i = 0; i < 256; i++) begin
			if (i < YEAR_COUNT) begin
				tab[i] = 16'(d);
				d = d + 365 + (leap_of_index(8'(i)) ? 1 : 0);
			end else begin
				tab[i] = 16'hFFFF;
			end
		end
		return tab;
	endfunction

	localparam year_tab_t YEAR_START = year_start_tab();

	localparam mon_tab_t MON_START_COMMON = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212,
		9'd243, 9'd273, 9'd304, 9'd334, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF
	};

	localparam mon_tab_t MON_START_LEAP = '{
		9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182, 9'd213,
		9'd244, 9'd274, 9'd305, 9'd335, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF
	};

	function automatic logic [8:0] mon_start(logic leap, logic [3:0] idx);
		return leap ? MON_START_LEAP[idx] : MON_START_COMMON[idx];
	endfunction

	// (days + 4) mod 7 by folding octal digits, since 8 is 1 mod 7
	function automatic logic [2:0] weekday_of(logic [15:0] days);
		logic [16:0] x;
		logic [5:0]  s1;
		logic [3:0]  s2;
		x  = {1'b0, days} + {12'd0, THURSDAY};
		s1 = {3'd0, x[2:0]} + {3'd0, x[5:3]} + {3'd0, x[8:6]}
			+ {3'd0, x[11:9]} + {3'd0, x[14:12]} + {4'd0, x[16:15]};
		s2 = {1'b0, s1[2:0]} + {1'b0, s1[5:3]};
		return (s2 >= WEEK_DAYS) ? 3'(s2 - WEEK_DAYS) : s2[2:0];
	endfunction

endpackage

// File: hw/rtl/ests_chan_if.sv
interface ests_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/ests_sub_unit.sv
// shared compare and subtract unit
module ests_sub_unit (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] diff,
	output logic        ge
);
	logic [32:0] wide;

	// borrow out of the 33-bit difference gives the compare
	assign wide = {1'b0, a} - {1'b0, b};
	assign ge   = ~wide[32];
	assign diff = wide[31:0];
endmodule

// File: hw/rtl/epoch_seconds_to_calendar.sv
// channel | dir | payload                 | handshake
// stamp   | in  | ests_pkg::stamp_t       | valid/ready
// date    | out | ests_pkg::date_t        | valid/ready
//
// a valid stamp goes from acceptance to result through 16 division steps for
// the day count, 5 and 6 for hour and minute, 8 for the binary year search,
// 4 for the month search and single day-of-year and day-of-month steps, all
// on one shared 32-bit compare and subtract unit; rejects go to the final step.
// arst_n clears the sequencer and the output valid flag.
// stamp is accepted only while the sequencer is idle; a result waiting on
// date does not block acceptance, it only holds the final step until taken.
module epoch_seconds_to_calendar (
	input logic        clk,
	input logic        arst_n,
	ests_chan_if.sink   stamp,
	ests_chan_if.source date
);

	ests_pkg::phase_t phase_q;
	logic [3:0]       step_q;
	logic             out_valid_q;
	ests_pkg::date_t  out_q;

	logic [31:0] acc_q;
	logic [15:0] days_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [7:0]  yidx_q;
	logic [8:0]  doy_q;
	logic [3:0]  mon_q;
	logic [2:0]  wd_q;
	logic        lp_q;
	logic        bad_q;

	logic [31:0] alu_a;
	logic [31:0] alu_b;
	logic [31:0] alu_diff;
	logic        alu_ge;
	logic [7:0]  year_cand;
	logic [3:0]  mon_cand;
	logic [15:0] days_w;
	logic        step_last;
	logic        out_load;
	logic        reject;
	ests_pkg::date_t result;

	assign year_cand = yidx_q | (8'd1 << step_q[2:0]);
	assign mon_cand  = mon_q | (4'd1 << step_q[1:0]);
	assign days_w    = {days_q[15:1], alu_ge};
	assign step_last = (step_q == 4'd0);
	assign out_load  = (phase_q == ests_pkg::PH_DOM) && (!out_valid_q || date.ready);
	assign reject    = bad_q || (days_w >= ests_pkg::DAY_LIMIT);

	// operand selection for the shared unit
	always_comb begin
		alu_a = acc_q;
		alu_b = '0;
		case (phase_q)
			ests_pkg::PH_DAY: begin
				alu_b = {15'd0, ests_pkg::DAY_SECS} << step_q;
			end
			ests_pkg::PH_HOUR: begin
				alu_b = {20'd0, ests_pkg::HOUR_SECS} << step_q;
			end
			ests_pkg::PH_MIN: begin
				alu_b = {26'd0, ests_pkg::MIN_SECS} << step_q;
			end
			ests_pkg::PH_YEAR: begin
				alu_a = {16'd0, days_q};
				alu_b = {16'd0, ests_pkg::YEAR_START[year_cand]};
			end
			ests_pkg::PH_YDOY: begin
				alu_a = {16'd0, days_q};
				alu_b = {16'd0, ests_pkg::YEAR_START[yidx_q]};
			end
			ests_pkg::PH_MON: begin
				alu_a = {23'd0, doy_q};
				alu_b = {23'd0, ests_pkg::mon_start(lp_q, mon_cand)};
			end
			ests_pkg::PH_DOM: begin
				alu_a = {23'd0, doy_q};
				alu_b = {23'd0, ests_pkg::mon_start(lp_q, mon_q)};
			end
			default: begin
				alu_a = acc_q;
				alu_b = '0;
			end
		endcase
	end

	ests_sub_unit u_sub (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ests_pkg::PH_IDLE;
			step_q  <= '0;
		end else begin
			case (phase_q)
				ests_pkg::PH_IDLE: begin
					if (stamp.valid) begin
						phase_q <= ests_pkg::PH_DAY;
						step_q  <= ests_pkg::DAY_STEPS_M1;
					end
				end
				ests_pkg::PH_DAY: begin
					if (step_last) begin
						phase_q <= reject ? ests_pkg::PH_DOM : ests_pkg::PH_HOUR;
						step_q  <= ests_pkg::HOUR_STEPS_M1;
					end else begin
						step_q <= step_q - 4'd1;
					end
				end
				ests_pkg::PH_HOUR: begin
					if (step_last) begin
						phase_q <= ests_pkg::PH_MIN;
						step_q  <= ests_pkg::MIN_STEPS_M1;
					end else begin
						step_q <= step_q - 4'd1;
					end
				end
				ests_pkg::PH_MIN: begin
					if (step_last) begin
						phase_q <= ests_pkg::PH_YEAR;
						step_q  <= ests_pkg::YEAR_STEPS_M1;
					end else begin
						step_q <= step_q - 4'd1;
					end
				end
				ests_pkg::PH_YEAR: begin
					if (step_last) begin
						phase_q <= ests_pkg::PH_YDOY;
					end else begin
						step_q <= step_q - 4'd1;
					end
				end
				ests_pkg::PH_YDOY: begin
					phase_q <= ests_pkg::PH_MON;
					step_q  <= ests_pkg::MON_STEPS_M1;
				end
				ests_pkg::PH_MON: begin
					if (step_last) begin
						phase_q <= ests_pkg::PH_DOM;
					end else begin
						step_q <= step_q - 4'd1;
					end
				end
				ests_pkg::PH_DOM: begin
					if (out_load) begin
						phase_q <= ests_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_q <= ests_pkg::PH_IDLE;
					step_q  <= '0;
				end
			endcase
		end
	end

	// datapath registers, one quotient or search bit per division or search step
	always_ff @(posedge clk) begin
		case (phase_q)
			ests_pkg::PH_IDLE: begin
				if (stamp.valid) begin
					acc_q  <= stamp.payload.epoch_seconds;
					bad_q  <= &stamp.payload.epoch_seconds;
					yidx_q <= '0;
					mon_q  <= '0;
				end
			end
			ests_pkg::PH_DAY: begin
				if (alu_ge) begin
					acc_q <= alu_diff;
				end
				days_q[step_q] <= alu_ge;
				if (step_last) begin
					bad_q <= reject;
					wd_q  <= ests_pkg::weekday_of(days_w);
				end
			end
			ests_pkg::PH_HOUR: begin
				if (alu_ge) begin
					acc_q <= alu_diff;
				end
				hour_q[step_q[2:0]] <= alu_ge;
			end
			ests_pkg::PH_MIN: begin
				if (alu_ge) begin
					acc_q <= alu_diff;
				end
				min_q[step_q[2:0]] <= alu_ge;
			end
			ests_pkg::PH_YEAR: begin
				if (alu_ge) begin
					yidx_q <= year_cand;
				end
			end
			ests_pkg::PH_YDOY: begin
				doy_q <= alu_diff[8:0];
				lp_q  <= ests_pkg::leap_of_index(yidx_q);
			end
			ests_pkg::PH_MON: begin
				if (alu_ge) begin
					mon_q <= mon_cand;
				end
			end
			default: begin
			end
		endcase
	end

	// result assembly, all zero when rejected
	always_comb begin
		result = '0;
		if (!bad_q) begin
			result.valid_res       = 1'b1;
			result.second          = acc_q[5:0];
			result.minute          = min_q;
			result.hour            = hour_q;
			result.weekday         = wd_q;
			result.year_since_1900 = ests_pkg::YEAR_OFS + yidx_q;
			result.day_of_year     = doy_q;
			result.month           = mon_q;
			result.day_of_month    = alu_diff[4:0] + 5'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (date.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= result;
		end
	end

	assign stamp.ready  = (phase_q == ests_pkg::PH_IDLE);
	assign date.valid   = out_valid_q;
	assign date.payload = out_q;

	// checks
	a_accept_starts_day: assert property (@(posedge clk) disable iff (!arst_n)
		stamp.valid && stamp.ready |=> phase_q == ests_pkg::PH_DAY
			&& step_q == ests_pkg::DAY_STEPS_M1)
		else $error("transaction accepted without starting the day division");

	a_rem_in_day: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ests_pkg::PH_HOUR |-> acc_q < {15'd0, ests_pkg::DAY_SECS})
		else $error("remainder not below one day after division");

	a_valid_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		date.valid && date.payload.valid_res |-> date.payload.month <= 4'd11
			&& date.payload.day_of_month != 5'd0 && date.payload.hour <= 5'd23
			&& date.payload.weekday <= 3'd6)
		else $error("converted date field out of range");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		date.valid && !date.payload.valid_res |-> date.payload.year_since_1900 == 8'd0
			&& date.payload.day_of_month == 5'd0 && date.payload.second == 6'd0)
		else $error("rejected result carries nonzero fields");

endmodule

// File: sim/tb.sv
module tb;

	localparam int unsigned STALL_LIMIT  = 3000;
	localparam int unsigned RANDOM_ITEMS = 1150;
	localparam int unsigned SETTLE_CYCLES = 60;

	// expected calendar dates, in stamp order, and the conversion that fills them
	class date_book;
		localparam int unsigned DAY_SECONDS  = 86400;
		localparam int unsigned DAYS_IN_RANGE = 49673;
		localparam int unsigned EPOCH_YEAR   = 1970;
		localparam int unsigned EPOCH_WEEKDAY = 4;

		ests_pkg::date_t dates_due[$];
		int unsigned     faults;

		function new();
			faults = 0;
		endfunction

		function int unsigned leap(int unsigned yr);
			if (yr % 4 != 0) return 0;
			if (yr % 100 != 0) return 1;
			return (yr % 400 == 0) ? 1 : 0;
		endfunction

		// day of year on which month m starts, m == 12 gives the year length
		function int unsigned month_first(int unsigned lp, int unsigned m);
			int unsigned d;
			case (m)
				0: d = 0;
				1: d = 31;
				2: d = 59;
				3: d = 90;
				4: d = 120;
				5: d = 151;
				6: d = 181;
				7: d = 212;
				8: d = 243;
				9: d = 273;
				10: d = 304;
				11: d = 334;
				default: d = 365;
			endcase
			return d + ((m >= 2) ? lp : 0);
		endfunction

		// day number of january 1 of year yr
		function int unsigned year_first_day(int unsigned yr);
			int unsigned d;
			d = 0;
			for (int unsigned y = EPOCH_YEAR; y < yr; y++) d += 365 + leap(y);
			return d;
		endfunction

		function ests_pkg::date_t civil_date_of(logic [31:0] secs);
			ests_pkg::date_t d;
			int unsigned     days;
			int unsigned     rem;
			int unsigned     yr;
			int unsigned     mon;
			int unsigned     lp;
			d = '0;
			// all ones marks an error, and the 32-bit count runs past 2105
			if (secs == '1) return d;
			days = secs / DAY_SECONDS;
			if (days >= DAYS_IN_RANGE) return d;
			rem = secs - days * DAY_SECONDS;
			d.valid_res = 1'b1;
			d.second    = 6'(rem % 60);
			d.minute    = 6'((rem / 60) % 60);
			d.hour      = 5'(rem / 3600);
			d.weekday   = 3'((days + EPOCH_WEEKDAY) % 7);
			// walk whole years, then whole months
			yr = EPOCH_YEAR;
			while (days >= 365 + leap(yr)) begin
				days -= 365 + leap(yr);
				yr++;
			end
			lp = leap(yr);
			mon = 0;
			while (mon < 11 && days >= month_first(lp, mon + 1)) mon++;
			d.year_since_1900 = 8'(yr - 1900);
			d.day_of_year     = 9'(days);
			d.month           = 4'(mon);
			d.day_of_month    = 5'(days - month_first(lp, mon) + 1);
			return d;
		endfunction

		function void note_stamp(ests_pkg::stamp_t s);
			dates_due.push_back(civil_date_of(s.epoch_seconds));
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				faults++;
				$display("%0t date %s: expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_date(ests_pkg::date_t got);
			ests_pkg::date_t want;
			if (dates_due.size() == 0) begin
				faults++;
				$display("%0t date transaction with nothing expected: expected none, got %h",
					$time, got);
				return;
			end
			want = dates_due.pop_front();
			check_field("valid_res", want.valid_res, got.valid_res);
			check_field("second", want.second, got.second);
			check_field("minute", want.minute, got.minute);
			check_field("hour", want.hour, got.hour);
			check_field("weekday", want.weekday, got.weekday);
			check_field("year_since_1900", want.year_since_1900, got.year_since_1900);
			check_field("day_of_year", want.day_of_year, got.day_of_year);
			check_field("month", want.month, got.month);
			check_field("day_of_month", want.day_of_month, got.day_of_month);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ests_chan_if #(.payload_t(ests_pkg::stamp_t)) stamp_ch ();
	ests_chan_if #(.payload_t(ests_pkg::date_t))  date_ch ();

	epoch_seconds_to_calendar u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.stamp  (stamp_ch),
		.date   (date_ch)
	);

	date_book    book = new();
	int unsigned idle_cycles;

	// corner stamps: field extremes, leap days, the 2100 rule and the range edges
	logic [31:0] corner_stamps [24] = '{
		32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
		32'd94608000, 32'd94694400, 32'd951782400, 32'd978307199,
		32'd2147483647, 32'd2147483648, 32'd4102358400, 32'd4102444800,
		32'd4107542399, 32'd4107542400, 32'd4291747199, 32'd4291747200,
		32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
	};

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// random stamps, weighted toward day, year and month edges
	function automatic logic [31:0] pick_stamp();
		int unsigned sel;
		int unsigned yr;
		int unsigned day;
		int unsigned back;
		sel = $urandom_range(0, 99);
		back = $urandom_range(0, 1);
		if (sel < 35) begin
			return $urandom;
		end else if (sel < 55) begin
			day = $urandom_range(0, 49672);
			case ($urandom_range(0, 4))
				0: return day * 86400;
				1: return day * 86400 + 1;
				2: return day * 86400 + 86398;
				3: return day * 86400 + 86399;
				default: return day * 86400 + $urandom_range(0, 86399);
			endcase
		end else if (sel < 75) begin
			yr = $urandom_range(1970, 2105);
			day = book.year_first_day(yr);
			if (day > 0) day -= back;
			return day * 86400 + $urandom_range(0, 86399);
		end else if (sel < 88) begin
			yr = $urandom_range(1970, 2105);
			day = book.year_first_day(yr) + book.month_first(book.leap(yr), $urandom_range(0, 11));
			if (day > 0) day -= back;
			return day * 86400 + $urandom_range(0, 86399);
		end else if (sel < 96) begin
			return $urandom_range(32'd4291747200, 32'hFFFF_FFFE);
		end
		return back ? 32'hFFFF_FFFF : 32'd4291747199;
	endfunction

	task automatic send_stamp(input logic [31:0] secs);
		stamp_ch.valid   <= 1'b1;
		stamp_ch.payload <= secs;
		do @(posedge clk); while (!stamp_ch.ready);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (book.dates_due.size() != 0);
	endtask

	// sender: corner stamps back to back, a full drain, then random bursts
	initial begin
		int unsigned sent;
		int unsigned burst;
		int unsigned gap;
		stamp_ch.valid   <= 1'b0;
		stamp_ch.payload <= '0;
		wait (arst_n);
		@(posedge clk);
		foreach (corner_stamps[i]) send_stamp(corner_stamps[i]);
		stamp_ch.valid <= 1'b0;
		wait_drained();
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			for (int unsigned i = 0; i < burst; i++) send_stamp(pick_stamp());
			sent += burst;
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
			if (gap > 0) begin
				stamp_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		stamp_ch.valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.faults == 0 && book.dates_due.size() == 0) begin
			$display("epoch_seconds_to_calendar: match");
		end else begin
			$display("epoch_seconds_to_calendar: mismatch");
		end
		$finish;
	end

	// receiver: stretches of steady, random and patterned ready, with long hold-offs
	initial begin
		int unsigned stretch;
		int unsigned mode;
		logic [7:0]  mask;
		date_ch.ready <= 1'b0;
		wait (arst_n);
		stretch = 0;
		forever begin
			mode = $urandom_range(0, 3);
			mask = 8'($urandom);
			if (stretch % 40 == 1) begin
				repeat (400) begin
					@(posedge clk);
					date_ch.ready <= 1'b0;
				end
			end else begin
				for (int unsigned n = 0; n < 64; n++) begin
					@(posedge clk);
					case (mode)
						0: date_ch.ready <= 1'b1;
						1: date_ch.ready <= 1'($urandom);
						2: date_ch.ready <= mask[n % 8];
						default: date_ch.ready <= ($urandom_range(0, 7) != 0);
					endcase
				end
			end
			stretch++;
		end
	end

	// transaction monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (stamp_ch.valid && stamp_ch.ready) book.note_stamp(stamp_ch.payload);
			if (date_ch.valid && date_ch.ready) book.check_date(date_ch.payload);
			if ((stamp_ch.valid && stamp_ch.ready) || (date_ch.valid && date_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t no transaction for %0d cycles", $time, idle_cycles);
				$display("epoch_seconds_to_calendar: mismatch");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

endmodule

// File: epoch_seconds_to_calendar.f
hw/rtl/ests_pkg.sv
hw/rtl/ests_chan_if.sv
hw/rtl/ests_sub_unit.sv
hw/rtl/epoch_seconds_to_calendar.sv
sim/tb.sv
